[hw/rtl/irc_mlp_pkg.sv]
package irc_mlp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned TS_W      = 63;
  localparam int unsigned KEY_LEN   = 5;

  localparam logic [2:0] KIND_FRAME  = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_CMD    = 3'd2;
  localparam logic [2:0] KIND_MIDDLE = 3'd3;
  localparam logic [2:0] KIND_TRAIL  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_KEY     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_EMPTY_PFX   = 3'd3;
  localparam logic [2:0] ST_EMPTY_CMD   = 3'd4;
  localparam logic [2:0] ST_EMPTY_PARAM = 3'd5;
  localparam logic [2:0] ST_NO_LF       = 3'd6;
  localparam logic [2:0] ST_STRAY_CR    = 3'd7;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic [2:0]      kind;
    logic            token_first;
    logic [3:0]      param_index;
    logic            nick_byte;
    logic            line_done;
    logic [2:0]      status;
    logic            discarding;
    logic [TS_W-1:0] timestamp;
    logic [3:0]      param_count;
    logic [12:0]     line_length;
  } result_t;

  function automatic logic [7:0] time_key_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h74;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6D;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h3D;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/irc_mlp_ts_step.sv]
module irc_mlp_ts_step (
  input  logic [irc_mlp_pkg::TS_W-1:0] acc,
  input  logic [3:0]                   digit,
  output logic [irc_mlp_pkg::TS_W-1:0] sum,
  output logic                         ovf
);

  localparam int unsigned WW = irc_mlp_pkg::TS_W + 4;

  logic [WW-1:0] acc_ext;
  logic [WW-1:0] wide;

  assign acc_ext = {4'b0, acc};
  assign wide    = (acc_ext << 3) + (acc_ext << 1) + {{(WW-4){1'b0}}, digit};
  assign sum     = wide[irc_mlp_pkg::TS_W-1:0];
  assign ovf     = |wide[WW-1:irc_mlp_pkg::TS_W];

endmodule

[hw/rtl/irc_mlp_tagger.sv]
module irc_mlp_tagger #(
  parameter int unsigned MAX_PARAMS     = 15,
  parameter int unsigned MAX_LINE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [7:0]           data,
  output irc_mlp_pkg::result_t res
);

  localparam int unsigned PCW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned BCW = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned PCX = (PCW > 4) ? PCW : 4;
  localparam int unsigned BCX = (BCW > 13) ? BCW : 13;

  typedef enum logic [3:0] {
    PH_LINE_START   = 4'd0,
    PH_TS_KEY       = 4'd1,
    PH_TS_VAL       = 4'd2,
    PH_TS_SKIP      = 4'd3,
    PH_AFTER_TS     = 4'd4,
    PH_PREFIX_FIRST = 4'd5,
    PH_PREFIX       = 4'd6,
    PH_CMD_FIRST    = 4'd7,
    PH_CMD          = 4'd8,
    PH_PARAM_FIRST  = 4'd9,
    PH_MIDDLE       = 4'd10,
    PH_TRAIL_FIRST  = 4'd11,
    PH_TRAIL        = 4'd12,
    PH_EXPECT_LF    = 4'd13,
    PH_DISCARD      = 4'd14
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [2:0]                     key_pos_r, key_pos_nxt;
  logic [irc_mlp_pkg::TS_W-1:0]   ts_acc_r, ts_acc_nxt;
  logic [PCW-1:0]                 param_cnt_r, param_cnt_nxt;
  logic                           nick_r, nick_nxt;
  logic [BCW-1:0]                 byte_cnt_r, byte_cnt_nxt;

  logic [irc_mlp_pkg::TS_W-1:0]   ts_sum;
  logic                           ts_ovf;
  logic [PCW-1:0]                 pc_bump;
  logic [PCX-1:0]                 pidx_cur;
  logic [PCX-1:0]                 pidx_bump;
  logic [PCX-1:0]                 pc_ext;
  logic [BCW-1:0]                 bc_inc;
  logic [BCX-1:0]                 bc_ext;

  irc_mlp_ts_step u_ts_step (
    .acc   (ts_acc_r),
    .digit (data[3:0]),
    .sum   (ts_sum),
    .ovf   (ts_ovf)
  );

  assign pc_bump   = (param_cnt_r < PCW'(MAX_PARAMS)) ? param_cnt_r + 1'b1 : param_cnt_r;
  assign pidx_cur  = PCX'(param_cnt_r) - 1'b1;
  assign pidx_bump = PCX'(pc_bump) - 1'b1;
  assign pc_ext    = PCX'(param_cnt_r);
  assign bc_inc    = (byte_cnt_r < BCW'(MAX_LINE_BYTES)) ? byte_cnt_r + 1'b1 : byte_cnt_r;
  assign bc_ext    = BCX'(bc_inc);

  always_comb begin
    logic [2:0] err;
    logic       clear;
    logic [2:0] key_inc;
    err           = irc_mlp_pkg::ST_OK;
    clear         = 1'b0;
    key_inc       = key_pos_r + 3'd1;
    phase_nxt     = phase_r;
    key_pos_nxt   = key_pos_r;
    ts_acc_nxt    = ts_acc_r;
    param_cnt_nxt = param_cnt_r;
    nick_nxt      = nick_r;
    byte_cnt_nxt  = byte_cnt_r;
    res           = '0;
    res.byte_out  = data;

    if (phase_r == PH_DISCARD) begin
      res.discarding = 1'b1;
      if (data == irc_mlp_pkg::CH_LF) begin
        clear     = 1'b1;
        phase_nxt = PH_LINE_START;
      end
    end else begin
      byte_cnt_nxt = bc_inc;
      case (phase_r)
        PH_LINE_START, PH_AFTER_TS, PH_CMD_FIRST: begin
          if (phase_r == PH_LINE_START && data == irc_mlp_pkg::CH_AT) begin
            key_pos_nxt = 3'd0;
            phase_nxt   = PH_TS_KEY;
          end else if (phase_r != PH_CMD_FIRST && data == irc_mlp_pkg::CH_COLON) begin
            phase_nxt = PH_PREFIX_FIRST;
          end else if (data == irc_mlp_pkg::CH_SPACE || data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_EMPTY_CMD;
          end else begin
            res.kind        = irc_mlp_pkg::KIND_CMD;
            res.token_first = 1'b1;
            phase_nxt       = PH_CMD;
          end
        end
        PH_TS_KEY: begin
          if (data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else if (key_pos_r < 3'(irc_mlp_pkg::KEY_LEN) &&
                       data == irc_mlp_pkg::time_key_char(key_pos_r)) begin
            key_pos_nxt = key_inc;
            if (key_inc == 3'(irc_mlp_pkg::KEY_LEN)) begin
              phase_nxt = PH_TS_VAL;
            end
          end else begin
            err = irc_mlp_pkg::ST_BAD_KEY;
          end
        end
        PH_TS_VAL: begin
          if (data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else if (data == irc_mlp_pkg::CH_SPACE) begin
            phase_nxt = PH_AFTER_TS;
          end else if (data inside {[irc_mlp_pkg::CH_ZERO:irc_mlp_pkg::CH_NINE]}) begin
            if (ts_ovf) begin
              err = irc_mlp_pkg::ST_OVERFLOW;
            end else begin
              ts_acc_nxt = ts_sum;
            end
          end else begin
            phase_nxt = PH_TS_SKIP;
          end
        end
        PH_TS_SKIP: begin
          if (data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else if (data == irc_mlp_pkg::CH_SPACE) begin
            phase_nxt = PH_AFTER_TS;
          end
        end
        PH_PREFIX_FIRST, PH_PREFIX: begin
          if (data == irc_mlp_pkg::CH_SPACE) begin
            if (phase_r == PH_PREFIX_FIRST) begin
              err = irc_mlp_pkg::ST_EMPTY_PFX;
            end else begin
              phase_nxt = PH_CMD_FIRST;
            end
          end else if (data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else begin
            res.kind        = irc_mlp_pkg::KIND_PREFIX;
            res.token_first = (phase_r == PH_PREFIX_FIRST);
            nick_nxt        = (phase_r == PH_PREFIX_FIRST) ? 1'b1 : nick_r;
            if (data == irc_mlp_pkg::CH_BANG || data == irc_mlp_pkg::CH_AT) begin
              nick_nxt = 1'b0;
            end
            res.nick_byte = nick_nxt;
            phase_nxt     = PH_PREFIX;
          end
        end
        PH_CMD: begin
          if (data == irc_mlp_pkg::CH_SPACE) begin
            phase_nxt = PH_PARAM_FIRST;
          end else if (data == irc_mlp_pkg::CH_CR) begin
            phase_nxt = PH_EXPECT_LF;
          end else begin
            res.kind = irc_mlp_pkg::KIND_CMD;
          end
        end
        PH_PARAM_FIRST: begin
          if (data == irc_mlp_pkg::CH_SPACE || data == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_EMPTY_PARAM;
          end else if (data == irc_mlp_pkg::CH_COLON) begin
            param_cnt_nxt = pc_bump;
            phase_nxt     = PH_TRAIL_FIRST;
          end else begin
            param_cnt_nxt   = pc_bump;
            res.kind        = irc_mlp_pkg::KIND_MIDDLE;
            res.token_first = 1'b1;
            res.param_index = (pidx_bump > PCX'(15)) ? 4'd15 : pidx_bump[3:0];
            phase_nxt       = PH_MIDDLE;
          end
        end
        PH_MIDDLE: begin
          if (data == irc_mlp_pkg::CH_SPACE) begin
            phase_nxt = PH_PARAM_FIRST;
          end else if (data == irc_mlp_pkg::CH_CR) begin
            phase_nxt = PH_EXPECT_LF;
          end else begin
            res.kind        = irc_mlp_pkg::KIND_MIDDLE;
            res.param_index = (pidx_cur > PCX'(15)) ? 4'd15 : pidx_cur[3:0];
          end
        end
        PH_TRAIL_FIRST, PH_TRAIL: begin
          if (data == irc_mlp_pkg::CH_CR) begin
            phase_nxt = PH_EXPECT_LF;
          end else begin
            res.kind        = irc_mlp_pkg::KIND_TRAIL;
            res.token_first = (phase_r == PH_TRAIL_FIRST);
            res.param_index = (pidx_cur > PCX'(15)) ? 4'd15 : pidx_cur[3:0];
            phase_nxt       = PH_TRAIL;
          end
        end
        PH_EXPECT_LF: begin
          if (data == irc_mlp_pkg::CH_LF) begin
            res.line_done   = 1'b1;
            res.timestamp   = ts_acc_r;
            res.param_count = (pc_ext > PCX'(15)) ? 4'd15 : pc_ext[3:0];
            res.line_length = (bc_ext > BCX'(8191)) ? 13'd8191 : bc_ext[12:0];
            clear           = 1'b1;
            phase_nxt       = PH_LINE_START;
          end else begin
            err = irc_mlp_pkg::ST_NO_LF;
          end
        end
        default: begin
          res.discarding = 1'b1;
          phase_nxt      = PH_DISCARD;
        end
      endcase

      if (err != irc_mlp_pkg::ST_OK) begin
        res.status      = err;
        res.discarding  = 1'b1;
        res.kind        = irc_mlp_pkg::KIND_FRAME;
        res.token_first = 1'b0;
        res.param_index = 4'd0;
        res.nick_byte   = 1'b0;
        if (data == irc_mlp_pkg::CH_LF) begin
          clear     = 1'b1;
          phase_nxt = PH_LINE_START;
        end else begin
          phase_nxt = PH_DISCARD;
        end
      end
    end

    if (clear) begin
      key_pos_nxt   = 3'd0;
      ts_acc_nxt    = '0;
      param_cnt_nxt = '0;
      nick_nxt      = 1'b1;
      byte_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE_START;
      key_pos_r   <= 3'd0;
      ts_acc_r    <= '0;
      param_cnt_r <= '0;
      nick_r      <= 1'b1;
      byte_cnt_r  <= '0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      key_pos_r   <= key_pos_nxt;
      ts_acc_r    <= ts_acc_nxt;
      param_cnt_r <= param_cnt_nxt;
      nick_r      <= nick_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    en && phase_r == PH_TS_KEY |-> key_pos_r < 3'(irc_mlp_pkg::KEY_LEN))
    else $error("key match position past key length");

  assert property (@(posedge clk) disable iff (!rst_n)
    en && res.line_done |=> byte_cnt_r == '0 && param_cnt_r == '0 && ts_acc_r == '0)
    else $error("line counters not cleared after completed line");

  assert property (@(posedge clk) disable iff (!rst_n)
    en && (phase_r == PH_MIDDLE || phase_r == PH_TRAIL || phase_r == PH_TRAIL_FIRST)
    |-> param_cnt_r != '0)
    else $error("parameter phase with zero parameter count");

endmodule

[hw/rtl/irc_message_line_parser_core.sv]
// Throughput: one byte per cycle unless out_ready stalls the output; the
//   phase/counter update and the x10 timestamp accumulate sit between the input
//   register and the result register.
// Reset (rst_n low, synchronous): both stages empty, parser at line start,
//   timestamp, parameter and byte counters cleared, nickname flag set.
module irc_message_line_parser_core #(
  parameter int unsigned MAX_PARAMS     = 15,
  parameter int unsigned MAX_LINE_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte_out,
  output logic [2:0]                   out_kind,
  output logic                         out_token_first,
  output logic [3:0]                   out_param_index,
  output logic                         out_nick_byte,
  output logic                         out_line_done,
  output logic [2:0]                   out_status,
  output logic                         out_discarding,
  output logic [irc_mlp_pkg::TS_W-1:0] out_timestamp,
  output logic [3:0]                   out_param_count,
  output logic [12:0]                  out_line_length
);

  logic                 in_valid_r;
  logic [7:0]           in_data_r;
  logic                 out_valid_r;
  irc_mlp_pkg::result_t out_r;
  irc_mlp_pkg::result_t res;
  logic                 adv;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  irc_mlp_tagger #(
    .MAX_PARAMS     (MAX_PARAMS),
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_tagger (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .data  (in_data_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_r.byte_out;
  assign out_kind        = out_r.kind;
  assign out_token_first = out_r.token_first;
  assign out_param_index = out_r.param_index;
  assign out_nick_byte   = out_r.nick_byte;
  assign out_line_done   = out_r.line_done;
  assign out_status      = out_r.status;
  assign out_discarding  = out_r.discarding;
  assign out_timestamp   = out_r.timestamp;
  assign out_param_count = out_r.param_count;
  assign out_line_length = out_r.line_length;

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r)
    else $error("held input beat lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != irc_mlp_pkg::ST_OK |-> out_discarding && !out_line_done)
    else $error("error beat not marked as discarded");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != irc_mlp_pkg::KIND_FRAME |-> !out_discarding && !out_line_done)
    else $error("tagged beat marked as discarded or line end");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nick_byte |-> out_kind == irc_mlp_pkg::KIND_PREFIX)
    else $error("nickname flag outside prefix");

endmodule

[tb/irc_message_line_parser_core_tb.sv]
`timescale 1ns / 100ps

module irc_message_line_parser_core_tb;

  typedef enum logic [3:0] {
    P_START, P_KEY, P_TS_DIGITS, P_TS_SKIP, P_POST_TS, P_PFX_FIRST, P_PFX,
    P_CMD_FIRST, P_CMD, P_PARAM_FIRST, P_MIDDLE, P_TRAIL_FIRST, P_TRAIL,
    P_WAIT_LF, P_RESYNC
  } phase_t;

  localparam logic [63:0] TS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [39:0] TIME_KEY   = "time=";
  localparam int          PARAM_CAP  = 15;
  localparam int          LINE_CAP   = 4096;
  localparam int          RANDOM_LEN = 1500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_out;
  logic [2:0]  out_kind;
  logic        out_token_first;
  logic [3:0]  out_param_index;
  logic        out_nick_byte;
  logic        out_line_done;
  logic [2:0]  out_status;
  logic        out_discarding;
  logic [irc_mlp_pkg::TS_W-1:0] out_timestamp;
  logic [3:0]  out_param_count;
  logic [12:0] out_line_length;

  logic [7:0]           byte_stream[$];
  logic [7:0]           line_buf[$];
  irc_mlp_pkg::result_t pending_tags[$];

  int bytes_sent = 0;
  int total_bytes = 0;
  int tags_seen = 0;
  int mismatches = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_cycles = 0;
  bit hold_rx = 1'b0;
  bit hold_done = 1'b0;

  phase_t      phase = P_START;
  logic [2:0]  key_pos = '0;
  logic [63:0] ts_acc = '0;
  int          param_cnt = 0;
  bit          nick_on = 1'b1;
  int          line_bytes = 0;

  irc_message_line_parser_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_kind        (out_kind),
    .out_token_first (out_token_first),
    .out_param_index (out_param_index),
    .out_nick_byte   (out_nick_byte),
    .out_line_done   (out_line_done),
    .out_status      (out_status),
    .out_discarding  (out_discarding),
    .out_timestamp   (out_timestamp),
    .out_param_count (out_param_count),
    .out_line_length (out_line_length)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void restart_line();
    key_pos    = '0;
    ts_acc     = '0;
    param_cnt  = 0;
    nick_on    = 1'b1;
    line_bytes = 0;
  endfunction

  function automatic irc_mlp_pkg::result_t tag_byte(input logic [7:0] c);
    irc_mlp_pkg::result_t r;
    phase_t               nxt;
    logic [2:0]           err;
    logic [63:0]          d;
    r = '0;
    r.byte_out = c;
    nxt = phase;
    err = irc_mlp_pkg::ST_OK;
    if (phase == P_RESYNC) begin
      r.discarding = 1'b1;
      if (c == irc_mlp_pkg::CH_LF) begin
        restart_line();
        nxt = P_START;
      end
    end else begin
      if (line_bytes < LINE_CAP) line_bytes++;
      case (phase)
        P_START, P_POST_TS, P_CMD_FIRST: begin
          if (phase == P_START && c == irc_mlp_pkg::CH_AT) begin
            key_pos = '0;
            nxt = P_KEY;
          end else if (phase != P_CMD_FIRST && c == irc_mlp_pkg::CH_COLON) begin
            nxt = P_PFX_FIRST;
          end else if (c == irc_mlp_pkg::CH_SPACE || c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_EMPTY_CMD;
          end else begin
            r.kind = irc_mlp_pkg::KIND_CMD;
            r.token_first = 1'b1;
            nxt = P_CMD;
          end
        end
        P_KEY: begin
          if (c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else if (c == TIME_KEY[39 - 8 * int'(key_pos) -: 8]) begin
            key_pos++;
            if (key_pos == irc_mlp_pkg::KEY_LEN) nxt = P_TS_DIGITS;
          end else begin
            err = irc_mlp_pkg::ST_BAD_KEY;
          end
        end
        P_TS_DIGITS: begin
          if (c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else if (c == irc_mlp_pkg::CH_SPACE) begin
            nxt = P_POST_TS;
          end else if (c >= irc_mlp_pkg::CH_ZERO && c <= irc_mlp_pkg::CH_NINE) begin
            d = {56'd0, c - irc_mlp_pkg::CH_ZERO};
            if (ts_acc > (TS_LIMIT - d) / 10) err = irc_mlp_pkg::ST_OVERFLOW;
            else ts_acc = ts_acc * 10 + d;
          end else begin
            nxt = P_TS_SKIP;
          end
        end
        P_TS_SKIP: begin
          if (c == irc_mlp_pkg::CH_CR) err = irc_mlp_pkg::ST_STRAY_CR;
          else if (c == irc_mlp_pkg::CH_SPACE) nxt = P_POST_TS;
        end
        P_PFX_FIRST: begin
          if (c == irc_mlp_pkg::CH_SPACE) begin
            err = irc_mlp_pkg::ST_EMPTY_PFX;
          end else if (c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else begin
            r.kind = irc_mlp_pkg::KIND_PREFIX;
            r.token_first = 1'b1;
            nick_on = !(c == irc_mlp_pkg::CH_BANG || c == irc_mlp_pkg::CH_AT);
            r.nick_byte = nick_on;
            nxt = P_PFX;
          end
        end
        P_PFX: begin
          if (c == irc_mlp_pkg::CH_SPACE) begin
            nxt = P_CMD_FIRST;
          end else if (c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_STRAY_CR;
          end else begin
            r.kind = irc_mlp_pkg::KIND_PREFIX;
            if (c == irc_mlp_pkg::CH_BANG || c == irc_mlp_pkg::CH_AT) nick_on = 1'b0;
            r.nick_byte = nick_on;
          end
        end
        P_CMD: begin
          if (c == irc_mlp_pkg::CH_SPACE) nxt = P_PARAM_FIRST;
          else if (c == irc_mlp_pkg::CH_CR) nxt = P_WAIT_LF;
          else r.kind = irc_mlp_pkg::KIND_CMD;
        end
        P_PARAM_FIRST: begin
          if (c == irc_mlp_pkg::CH_SPACE || c == irc_mlp_pkg::CH_CR) begin
            err = irc_mlp_pkg::ST_EMPTY_PARAM;
          end else begin
            if (param_cnt < PARAM_CAP) param_cnt++;
            if (c == irc_mlp_pkg::CH_COLON) begin
              nxt = P_TRAIL_FIRST;
            end else begin
              r.kind = irc_mlp_pkg::KIND_MIDDLE;
              r.token_first = 1'b1;
              r.param_index = 4'(param_cnt - 1);
              nxt = P_MIDDLE;
            end
          end
        end
        P_MIDDLE: begin
          if (c == irc_mlp_pkg::CH_SPACE) begin
            nxt = P_PARAM_FIRST;
          end else if (c == irc_mlp_pkg::CH_CR) begin
            nxt = P_WAIT_LF;
          end else begin
            r.kind = irc_mlp_pkg::KIND_MIDDLE;
            r.param_index = 4'(param_cnt - 1);
          end
        end
        P_TRAIL_FIRST, P_TRAIL: begin
          if (c == irc_mlp_pkg::CH_CR) begin
            nxt = P_WAIT_LF;
          end else begin
            r.kind = irc_mlp_pkg::KIND_TRAIL;
            r.token_first = (phase == P_TRAIL_FIRST);
            r.param_index = 4'(param_cnt - 1);
            nxt = P_TRAIL;
          end
        end
        P_WAIT_LF: begin
          if (c == irc_mlp_pkg::CH_LF) begin
            r.line_done = 1'b1;
            r.timestamp = ts_acc[irc_mlp_pkg::TS_W-1:0];
            r.param_count = 4'(param_cnt);
            r.line_length = 13'(line_bytes);
            restart_line();
            nxt = P_START;
          end else begin
            err = irc_mlp_pkg::ST_NO_LF;
          end
        end
        default: begin
          r.discarding = 1'b1;
          nxt = P_RESYNC;
        end
      endcase
      if (err != irc_mlp_pkg::ST_OK) begin
        r.status = err;
        r.discarding = 1'b1;
        r.kind = irc_mlp_pkg::KIND_FRAME;
        r.token_first = 1'b0;
        r.param_index = '0;
        r.nick_byte = 1'b0;
        if (c == irc_mlp_pkg::CH_LF) begin
          restart_line();
          nxt = P_START;
        end else begin
          nxt = P_RESYNC;
        end
      end
    end
    phase = nxt;
    return r;
  endfunction

  function automatic bit may_idle();
    return (total_bytes - bytes_sent > 200) && ((bytes_sent / 256) % 3 != 2);
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("tag %0d byte %02h: %s want %0h got %0h",
                 tags_seen, out_byte_out, name, want, got);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] tok_byte(input bit no_colon, input bit no_at);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == irc_mlp_pkg::CH_SPACE || c == irc_mlp_pkg::CH_CR ||
           (no_colon && c == irc_mlp_pkg::CH_COLON) ||
           (no_at && c == irc_mlp_pkg::CH_AT));
    return c;
  endfunction

  function automatic logic [7:0] no_cr_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == irc_mlp_pkg::CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 5))
      0: return irc_mlp_pkg::CH_SPACE;
      1: return irc_mlp_pkg::CH_CR;
      2: return irc_mlp_pkg::CH_LF;
      3: return irc_mlp_pkg::CH_COLON;
      4: return irc_mlp_pkg::CH_AT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
  endtask

  task automatic end_line();
    byte_stream.push_back(irc_mlp_pkg::CH_CR);
    byte_stream.push_back(irc_mlp_pkg::CH_LF);
  endtask

  task automatic compose_line();
    int    i;
    int    j;
    int    n;
    int    np;
    bit    has_ts;
    bit    has_pfx;
    string ts_max;
    logic [7:0] c;
    ts_max = "9223372036854775807";
    line_buf.delete();
    has_ts = ($urandom_range(0, 2) == 0);
    has_pfx = $urandom_range(0, 1);
    if (has_ts) begin
      line_buf.push_back(irc_mlp_pkg::CH_AT);
      for (i = 0; i < irc_mlp_pkg::KEY_LEN; i++)
        line_buf.push_back(TIME_KEY[39 - 8 * i -: 8]);
      case ($urandom_range(0, 9))
        0: ;
        6: for (i = 0; i < ts_max.len(); i++) line_buf.push_back(ts_max[i]);
        7: begin
          for (i = 0; i < ts_max.len() - 1; i++) line_buf.push_back(ts_max[i]);
          line_buf.push_back(irc_mlp_pkg::CH_ZERO + 8'd8);
        end
        8: begin
          n = $urandom_range(19, 21);
          for (i = 0; i < n; i++)
            line_buf.push_back(irc_mlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        9: begin
          n = $urandom_range(1, 19);
          for (i = 0; i < n; i++) line_buf.push_back(irc_mlp_pkg::CH_ZERO);
          n = $urandom_range(1, 9);
          for (i = 0; i < n; i++)
            line_buf.push_back(irc_mlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        default: begin
          n = $urandom_range(1, 18);
          for (i = 0; i < n; i++)
            line_buf.push_back(irc_mlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        do c = tok_byte(1'b0, 1'b0);
        while (c >= irc_mlp_pkg::CH_ZERO && c <= irc_mlp_pkg::CH_NINE);
        line_buf.push_back(c);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) line_buf.push_back(tok_byte(1'b0, 1'b0));
      end
      line_buf.push_back(irc_mlp_pkg::CH_SPACE);
    end
    if (has_pfx) begin
      line_buf.push_back(irc_mlp_pkg::CH_COLON);
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0)
          line_buf.push_back($urandom_range(0, 1) ? irc_mlp_pkg::CH_BANG
                                                   : irc_mlp_pkg::CH_AT);
        else
          line_buf.push_back(tok_byte(1'b0, 1'b0));
      end
      line_buf.push_back(irc_mlp_pkg::CH_SPACE);
    end
    line_buf.push_back(tok_byte(!has_pfx, !has_pfx && !has_ts));
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) line_buf.push_back(tok_byte(1'b0, 1'b0));
    np = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 18);
    for (j = 0; j < np; j++) begin
      line_buf.push_back(irc_mlp_pkg::CH_SPACE);
      line_buf.push_back(tok_byte(1'b1, 1'b0));
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) line_buf.push_back(tok_byte(1'b0, 1'b0));
    end
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(irc_mlp_pkg::CH_SPACE);
      line_buf.push_back(irc_mlp_pkg::CH_COLON);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) line_buf.push_back(no_cr_byte());
    end
    line_buf.push_back(irc_mlp_pkg::CH_CR);
    line_buf.push_back(irc_mlp_pkg::CH_LF);
  endtask

  task automatic break_line();
    int pos;
    pos = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: line_buf[pos] = special_byte();
      1: line_buf.insert(pos, special_byte());
      2: line_buf.delete(pos);
      default: while (line_buf.size() > pos) void'(line_buf.pop_back());
    endcase
  endtask

  initial begin
    int  i;
    int  n;
    int  target;
    int  sel;

    push_str("A");
    end_line();
    end_line();
    push_str("@");
    byte_stream.push_back(irc_mlp_pkg::CH_LF);
    push_str("@x");
    byte_stream.push_back(irc_mlp_pkg::CH_LF);
    push_str(": ");
    byte_stream.push_back(irc_mlp_pkg::CH_LF);
    push_str("B  ");
    end_line();
    push_str("C");
    byte_stream.push_back(irc_mlp_pkg::CH_CR);
    push_str("D");
    byte_stream.push_back(irc_mlp_pkg::CH_LF);
    push_str(":n");
    end_line();
    byte_stream.push_back(8'hFF);
    byte_stream.push_back(8'h00);
    push_str(" :");
    end_line();

    target = byte_stream.size() + RANDOM_LEN;
    while (byte_stream.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 90) begin
        compose_line();
        if (sel >= 70) break_line();
        for (i = 0; i < line_buf.size(); i++) byte_stream.push_back(line_buf[i]);
      end else begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) byte_stream.push_back(8'($urandom_range(0, 255)));
      end
    end
    total_bytes = byte_stream.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_sent < total_bytes) @(posedge clk);
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_tags.size() == 0)
      $display("irc_message_line_parser_core_tb: clean");
    else
      $display("irc_message_line_parser_core_tb: errors");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("irc_message_line_parser_core_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_tags.push_back(tag_byte(in_data));
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_stream.size() == 0) begin
          in_valid <= 1'b0;
        end else if (may_idle() && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= byte_stream.pop_front();
        end
      end
    end
  end

  // hold off the receiver long enough to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_rx <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done) begin
      if (!hold_rx) begin
        if (bytes_sent >= 400) hold_rx <= 1'b1;
      end else if (hold_cycles == 300) begin
        hold_rx <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    irc_mlp_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tags.size() == 0) begin
          if (mismatches < 10)
            $display("tag %0d byte %02h: no beat was due", tags_seen, out_byte_out);
          mismatches++;
        end else begin
          want = pending_tags.pop_front();
          cmp_field("byte_out", want.byte_out, out_byte_out);
          cmp_field("kind", want.kind, out_kind);
          cmp_field("token_first", want.token_first, out_token_first);
          cmp_field("param_index", want.param_index, out_param_index);
          cmp_field("nick_byte", want.nick_byte, out_nick_byte);
          cmp_field("line_done", want.line_done, out_line_done);
          cmp_field("status", want.status, out_status);
          cmp_field("discarding", want.discarding, out_discarding);
          cmp_field("timestamp", want.timestamp, out_timestamp);
          cmp_field("param_count", want.param_count, out_param_count);
          cmp_field("line_length", want.line_length, out_line_length);
        end
        tags_seen++;
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule

[irc_message_line_parser_core.f]
hw/rtl/irc_mlp_pkg.sv
hw/rtl/irc_mlp_ts_step.sv
hw/rtl/irc_mlp_tagger.sv
hw/rtl/irc_message_line_parser_core.sv
tb/irc_message_line_parser_core_tb.sv
